FILE: rtl/core/hstoi_pkg.sv
// ----------------------------------------------------------------------------
// Hex string parser package
// Shared types, constants and character classification functions.
// ----------------------------------------------------------------------------
package hstoi_pkg;

    // Largest count of consumed characters that is reported.
    localparam int unsigned MAX_COUNT = 255;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned VALUE_W   = 64;

    // The count saturates at MAX_COUNT, and never beyond what the field holds.
    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        (MAX_COUNT < 255) ? COUNT_W'(MAX_COUNT) : COUNT_W'(255);

    // Characters of interest.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Value returned by hex_value for a character that is not a hex digit.
    localparam logic [4:0] NOT_HEX = 5'd16;

    // Phases of the parse.
    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_SIGN  = 2'd1,
        PH_DIGIT = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    // Parser state carried from one character to the next.
    typedef struct packed {
        phase_t               phase;
        logic                 minus_seen;
        logic [VALUE_W-1:0]   accumulator;
        logic [COUNT_W-1:0]   consumed_count;
        logic                 digit_seen;
    } parse_state_t;

    // One result word.
    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic [COUNT_W-1:0]   count;
        logic                 found;
    } parse_result_t;

    localparam parse_state_t STATE_CLEAR = '{
        phase:          PH_LEAD,
        minus_seen:     1'b0,
        accumulator:    '0,
        consumed_count: '0,
        digit_seen:     1'b0
    };

    // White space is blank, tab, line feed, vertical tab, form feed and return.
    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Digit value of a hex character, or NOT_HEX.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        hex_value = NOT_HEX;
        if ((c >= CH_ZERO) && (c <= CH_NINE))
        begin
            d = c - CH_ZERO;
            hex_value = d[4:0];
        end
        else if ((c >= CH_LO_A) && (c <= CH_LO_F))
        begin
            d = c - CH_LO_A + 8'd10;
            hex_value = d[4:0];
        end
        else if ((c >= CH_UP_A) && (c <= CH_UP_F))
        begin
            d = c - CH_UP_A + 8'd10;
            hex_value = d[4:0];
        end
    endfunction

    // Saturating increment of the consumed count.
    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] n);
        bump = (n < COUNT_LIMIT) ? n + COUNT_W'(1) : n;
    endfunction

endpackage

FILE: rtl/core/hstoi_parse_step.sv
// ----------------------------------------------------------------------------
// Hex string parser step
// Next-state and result logic for one character of the string.
// ----------------------------------------------------------------------------
module hstoi_parse_step
    import hstoi_pkg::*;
(
    input  parse_state_t  cur_state,
    input  logic [7:0]    char_byte,
    input  logic          end_of_string,
    output parse_state_t  next_state,
    output logic          result_ready,
    output parse_result_t result
);

    parse_state_t taken;
    logic [4:0]   digit;
    logic         to_digits;

    assign digit = hex_value(char_byte);

    // Apply one character to the state, unless it is the terminator or the
    // digits have already stopped.
    always_comb
    begin
        taken     = cur_state;
        to_digits = 1'b0;
        if ((char_byte != CH_NUL) && (cur_state.phase != PH_DONE))
        begin
            case (cur_state.phase)
                PH_LEAD:
                begin
                    if (is_space(char_byte))
                    begin
                        taken.consumed_count = bump(cur_state.consumed_count);
                    end
                    else if ((char_byte == CH_MINUS) || (char_byte == CH_PLUS))
                    begin
                        taken.minus_seen     = (char_byte == CH_MINUS);
                        taken.consumed_count = bump(cur_state.consumed_count);
                        taken.phase          = PH_SIGN;
                    end
                    else
                    begin
                        to_digits = 1'b1;
                    end
                end
                PH_SIGN:
                begin
                    if (is_space(char_byte))
                    begin
                        taken.consumed_count = bump(cur_state.consumed_count);
                    end
                    else
                    begin
                        to_digits = 1'b1;
                    end
                end
                PH_DIGIT:
                begin
                    to_digits = 1'b1;
                end
                default:
                begin
                    to_digits = 1'b0;
                end
            endcase

            // Gather a digit, or stop at the first byte that is not one.
            if (to_digits)
            begin
                if (digit != NOT_HEX)
                begin
                    taken.phase          = PH_DIGIT;
                    taken.accumulator    = {cur_state.accumulator[VALUE_W-5:0], digit[3:0]};
                    taken.digit_seen     = 1'b1;
                    taken.consumed_count = bump(cur_state.consumed_count);
                end
                else
                begin
                    taken.phase = PH_DONE;
                end
            end
        end
    end

    // The string ends on a zero byte or on the end flag.
    assign result_ready = (char_byte == CH_NUL) || end_of_string;

    always_comb
    begin
        if (taken.digit_seen)
        begin
            result.value = taken.minus_seen ? (VALUE_W'(0) - taken.accumulator)
                                            : taken.accumulator;
            result.count = taken.consumed_count;
            result.found = 1'b1;
        end
        else
        begin
            result.value = '0;
            result.count = '0;
            result.found = 1'b0;
        end
    end

    // Clear for the next string once a result has been given.
    assign next_state = result_ready ? STATE_CLEAR : taken;

endmodule

FILE: rtl/core/hex_string_to_integer.sv
// ----------------------------------------------------------------------------
// Hex string to integer
// Parses a stream of characters into a signed 64-bit value.
// ----------------------------------------------------------------------------
// One character word is taken per cycle while char_stall is low. Each word is
// registered in char_reg, applied combinationally to the parse state and,
// when it ends the string (a zero byte or end_of_string high), one result
// word is written to the output register out_reg. Leading white space, an
// optional sign and further white space are skipped; hex digits are gathered
// modulo 2^64 until the first non-digit, after which bytes are ignored until
// the string ends. The count includes white space and sign and saturates at
// MAX_COUNT; a string with no digit gives zero value, zero count and
// number_found low. The input is stalled only while a finished result waits
// on a stalled output.
module hex_string_to_integer
    import hstoi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_stall,
    input  logic [7:0]          char_byte,
    input  logic                end_of_string,
    output logic                result_valid,
    input  logic                result_stall,
    output logic signed [63:0]  parsed_value,
    output logic [7:0]          parsed_count,
    output logic                number_found
);

    logic          in_valid_reg;
    logic          in_valid_next;
    logic [7:0]    char_reg;
    logic          eos_reg;
    parse_state_t  state_reg;
    parse_state_t  state_step;
    logic          out_valid_reg;
    logic          out_valid_next;
    parse_result_t out_reg;
    parse_result_t step_result;
    logic          step_ends;
    logic          out_free;
    logic          advance;
    logic          accept;

    // Parse logic for the registered character.
    hstoi_parse_step u_step (
        .cur_state     (state_reg),
        .char_byte     (char_reg),
        .end_of_string (eos_reg),
        .next_state    (state_step),
        .result_ready  (step_ends),
        .result        (step_result)
    );

    // The registered word moves on unless its result has nowhere to go.
    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = in_valid_reg && (!step_ends || out_free);
    assign char_stall = in_valid_reg && !advance;
    assign accept     = char_valid && !char_stall;

    assign in_valid_next = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && step_ends)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_CLEAR;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_step;
            end
        end
    end

    // Input and result word registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= char_byte;
            eos_reg  <= end_of_string;
        end
        if (advance && step_ends)
        begin
            out_reg <= step_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign parsed_value = $signed(out_reg.value);
    assign parsed_count = out_reg.count;
    assign number_found = out_reg.found;

endmodule
